// ===== src/window_time_weighted_stats_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef WINDOW_TIME_WEIGHTED_STATS_ASSERT_SVH
`define WINDOW_TIME_WEIGHTED_STATS_ASSERT_SVH

// Concurrent check on clk, quiet while arst_n is low.
`define WTWS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// The expression must never hold.
`define WTWS_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ===== src/wtws_pkg.sv =====
`timescale 1ns / 1ps
package wtws_pkg;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_ERROR = 2'd2;

	localparam logic [1:0] MODE_MEAN = 2'd0;
	localparam logic [1:0] MODE_MIN  = 2'd1;
	localparam logic [1:0] MODE_MAX  = 2'd2;

	localparam logic [1:0] REG_WINDOW_START    = 2'd0;
	localparam logic [1:0] REG_WINDOW_END      = 2'd1;
	localparam logic [1:0] REG_STAT_MODE       = 2'd2;
	localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd3;

	localparam int unsigned DIV_STEPS = 64;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [31:0]        sample_time;
		logic signed [31:0] sample_value;
		logic               last_sample;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] stat_value;
	} out_item_t;

	typedef struct packed {
		logic               add1_en;
		logic signed [31:0] add1_value;
		logic [15:0]        add1_weight;
		logic               add2_en;
		logic signed [31:0] add2_value;
		logic               fin;
		logic               need_div;
		logic [1:0]         status;
		logic [31:0]        value;
	} rec_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DIV,
		ST_OUT
	} back_state_t;

endpackage

// ===== src/wtws_front.sv =====
`timescale 1ns / 1ps
module wtws_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [31:0]      cfg_wdata,
	input  logic             accept,
	input  wtws_pkg::in_item_t item,
	output wtws_pkg::rec_t   rec
);
	import wtws_pkg::*;

	logic [31:0]        win_start_q;
	logic [31:0]        win_end_q;
	logic [1:0]         mode_q;
	logic [15:0]        interval_q;

	logic [31:0]        ptime_q;
	logic signed [31:0] pvalue_q;
	logic               pvalid_q;
	logic               closed_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;
	logic               has_w_q;
	logic [1:0]         seen_q;
	logic               order_err_q;

	logic [31:0]        t;
	logic signed [31:0] v;
	logic               order_bad;
	logic [31:0]        gap;
	logic [31:0]        cut;
	logic [15:0]        w;
	logic               add1;
	logic               closed_n;
	logic               inwin;
	logic               has_w_n;
	logic signed [31:0] min_n;
	logic signed [31:0] max_n;
	logic signed [31:0] pvalue_n;
	logic               pvalid_n;
	logic [31:0]        ptime_n;
	logic [1:0]         seen_n;
	logic               order_err_n;
	logic               has_w_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= '0;
			win_end_q   <= 32'd1;
			mode_q      <= MODE_MEAN;
			interval_q  <= 16'd5;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WINDOW_START:    win_start_q <= cfg_wdata;
				REG_WINDOW_END:      win_end_q   <= cfg_wdata;
				REG_STAT_MODE:       mode_q      <= cfg_wdata[1:0];
				REG_REPEAT_INTERVAL: interval_q  <= cfg_wdata[15:0];
				default:             win_start_q <= win_start_q;
			endcase
		end
	end

	assign t   = item.sample_time;
	assign v   = item.sample_value;
	assign gap = t - ptime_q;
	assign cut = win_end_q - ptime_q;

	always_comb begin
		order_bad   = (seen_q != 2'd0) && (t <= ptime_q);
		add1        = 1'b0;
		closed_n    = closed_q;
		inwin       = 1'b0;
		has_w_n     = has_w_q;
		min_n       = min_q;
		max_n       = max_q;
		pvalue_n    = pvalue_q;
		pvalid_n    = pvalid_q;
		ptime_n     = ptime_q;
		seen_n      = seen_q;
		order_err_n = order_err_q;
		if (gap > {16'd0, interval_q}) begin
			w = 16'd1;
		end else if (t < win_end_q) begin
			w = gap[15:0];
		end else if (win_end_q > ptime_q) begin
			w = cut[15:0];
		end else begin
			w = 16'd1;
		end
		if (order_bad) begin
			order_err_n = 1'b1;
		end else begin
			add1     = pvalid_q;
			has_w_n  = has_w_q | pvalid_q;
			closed_n = closed_q | (t >= win_end_q);
			inwin    = !closed_n && (t >= win_start_q) && (t < win_end_q);
			if (inwin) begin
				if (!has_w_n) begin
					min_n = v;
					max_n = v;
				end else begin
					if (v < min_q) min_n = v;
					if (v > max_q) max_n = v;
				end
				pvalue_n = v;
			end
			pvalid_n = inwin;
			ptime_n  = t;
			if (seen_q != 2'd2) seen_n = seen_q + 2'd1;
		end
		has_w_fin = has_w_n | pvalid_n;
	end

	always_comb begin
		rec.add1_en     = add1;
		rec.add1_value  = pvalue_q;
		rec.add1_weight = w;
		rec.add2_en     = item.last_sample && pvalid_n;
		rec.add2_value  = pvalue_n;
		rec.fin         = item.last_sample;
		rec.need_div    = 1'b0;
		rec.status      = STATUS_ERROR;
		rec.value       = '0;
		if ((win_start_q >= win_end_q) || order_err_n) begin
			rec.status = STATUS_ERROR;
		end else if (!has_w_fin) begin
			rec.status = STATUS_EMPTY;
		end else begin
			unique case (mode_q)
				MODE_MEAN: begin
					rec.status   = STATUS_OK;
					rec.need_div = 1'b1;
				end
				MODE_MIN: begin
					rec.status = STATUS_OK;
					rec.value  = min_n;
				end
				MODE_MAX: begin
					rec.status = STATUS_OK;
					rec.value  = max_n;
				end
				default: rec.status = STATUS_ERROR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptime_q     <= '0;
			pvalue_q    <= '0;
			pvalid_q    <= 1'b0;
			closed_q    <= 1'b0;
			min_q       <= '0;
			max_q       <= '0;
			has_w_q     <= 1'b0;
			seen_q      <= '0;
			order_err_q <= 1'b0;
		end else if (accept) begin
			if (item.last_sample) begin
				ptime_q     <= '0;
				pvalue_q    <= '0;
				pvalid_q    <= 1'b0;
				closed_q    <= 1'b0;
				min_q       <= '0;
				max_q       <= '0;
				has_w_q     <= 1'b0;
				seen_q      <= '0;
				order_err_q <= 1'b0;
			end else begin
				ptime_q     <= ptime_n;
				pvalue_q    <= pvalue_n;
				pvalid_q    <= pvalid_n;
				closed_q    <= closed_n;
				min_q       <= min_n;
				max_q       <= max_n;
				has_w_q     <= has_w_n;
				seen_q      <= seen_n;
				order_err_q <= order_err_n;
			end
		end
	end

endmodule

// ===== src/wtws_queue.sv =====
`timescale 1ns / 1ps
module wtws_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wtws_pkg::rec_t push_rec,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output wtws_pkg::rec_t head_rec
);
	import wtws_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rec_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_rec   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/wtws_back.sv =====
`timescale 1ns / 1ps
module wtws_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  wtws_pkg::rec_t    head_rec,
	output logic              pop,
	output logic              done,
	output wtws_pkg::out_item_t result
);
	import wtws_pkg::*;

	back_state_t        state_q;
	back_state_t        state_n;

	logic               hold_q;
	logic               s1_valid_s1;
	logic signed [63:0] p1_s1;
	logic signed [63:0] p2_s1;
	logic [16:0]        w_s1;
	logic               fin_s1;
	logic               need_div_s1;
	logic [1:0]         status_s1;
	logic [31:0]        value_s1;

	logic [63:0]        sum_q;
	logic [31:0]        wt_q;
	logic               fin_q;
	logic               need_div_q;
	logic [1:0]         status_q;
	logic [31:0]        value_q;

	logic               neg_q;
	logic [63:0]        dvd_q;
	logic [31:0]        rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic               done_q;
	out_item_t          result_q;

	logic signed [48:0] prod;
	logic [32:0]        wt_sum;
	logic [32:0]        shifted;
	logic               ge;
	logic [32:0]        diff;
	logic [31:0]        mean;

	logic               emit;
	logic               load_div;
	logic [1:0]         emit_status;
	logic [31:0]        emit_value;

	assign pop  = head_valid && !hold_q;
	assign prod = head_rec.add1_value * $signed({1'b0, head_rec.add1_weight});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			p1_s1       <= head_rec.add1_en ? {{15{prod[48]}}, prod} : 64'sd0;
			p2_s1       <= head_rec.add2_en ? {{32{head_rec.add2_value[31]}}, head_rec.add2_value}
			                                : 64'sd0;
			w_s1        <= (head_rec.add1_en ? {1'b0, head_rec.add1_weight} : 17'd0)
			             + (head_rec.add2_en ? 17'd1 : 17'd0);
			fin_s1      <= head_rec.fin;
			need_div_s1 <= head_rec.need_div;
			status_s1   <= head_rec.status;
			value_s1    <= head_rec.value;
		end
	end

	assign wt_sum = {1'b0, wt_q} + {16'd0, w_s1};

	assign shifted = {rem_q, dvd_q[63]};
	assign ge      = (shifted >= {1'b0, wt_q});
	assign diff    = shifted - {1'b0, wt_q};

	always_comb begin
		if (!neg_q) begin
			mean = (|dvd_q[63:31]) ? 32'h7FFF_FFFF : dvd_q[31:0];
		end else if ((|dvd_q[63:32]) || (dvd_q[31] && (|dvd_q[30:0]))) begin
			mean = 32'h8000_0000;
		end else begin
			mean = ~dvd_q[31:0] + 32'd1;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_RUN: if (fin_q && need_div_q) state_n = ST_DIV;
			ST_DIV: if (cnt_q == '0) state_n = ST_OUT;
			ST_OUT: state_n = ST_RUN;
			default: state_n = ST_RUN;
		endcase
	end

	always_comb begin
		emit        = 1'b0;
		load_div    = 1'b0;
		emit_status = status_q;
		emit_value  = value_q;
		unique case (state_q)
			ST_RUN: begin
				if (fin_q) begin
					load_div = need_div_q;
					emit     = !need_div_q;
				end
			end
			ST_DIV: begin
				emit = 1'b0;
			end
			ST_OUT: begin
				emit        = 1'b1;
				emit_status = STATUS_OK;
				emit_value  = mean;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			hold_q  <= 1'b0;
			fin_q   <= 1'b0;
			sum_q   <= '0;
			wt_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= emit;
			if (pop && head_rec.fin) begin
				hold_q <= 1'b1;
			end else if (emit) begin
				hold_q <= 1'b0;
			end
			if (s1_valid_s1) begin
				sum_q <= sum_q + 64'(p1_s1) + 64'(p2_s1);
				wt_q  <= wt_sum[32] ? 32'hFFFF_FFFF : wt_sum[31:0];
				fin_q <= fin_s1;
			end else if (emit) begin
				sum_q <= '0;
				wt_q  <= '0;
				fin_q <= 1'b0;
			end else if (load_div) begin
				fin_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			need_div_q <= need_div_s1;
			status_q   <= status_s1;
			value_q    <= value_s1;
		end
		if (load_div) begin
			neg_q <= sum_q[63];
			dvd_q <= sum_q[63] ? (~sum_q + 64'd1) : sum_q;
			rem_q <= '0;
			cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			dvd_q <= {dvd_q[62:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
		if (emit) begin
			result_q.status     <= emit_status;
			result_q.stat_value <= emit_value;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== src/window_time_weighted_stats.sv =====
`timescale 1ns / 1ps
// Time-weighted mean, minimum or maximum of a set of timestamped samples over
// the window set by window_start and window_end. A sample is taken on every
// cycle with start high and busy low; the sample flagged last_sample closes the
// set, and its result appears once, for one cycle with done high, and is never
// held back. Samples enter a queue of QUEUE_DEPTH entries and busy is high only
// while that queue is full. The back end reads one entry per cycle through a
// multiply and accumulate, except while it holds after a last sample until that
// set's result is out; a minimum, maximum or error result follows the accumulate,
// and a mean follows the 64-by-32 bit division, which retires one quotient bit per
// cycle. Samples of the next set are taken into the queue meanwhile. Registers
// must be written only while the block is idle; the block does not enforce this.
module window_time_weighted_stats #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [31:0]         cfg_wdata,
	input  logic                start,
	output logic                busy,
	input  wtws_pkg::in_item_t  sample,
	output logic                done,
	output wtws_pkg::out_item_t result
);
	import wtws_pkg::*;

	logic accept;
	logic full;
	logic head_valid;
	logic pop;
	rec_t push_rec;
	rec_t head_rec;

	assign busy   = full;
	assign accept = start && !full;

	wtws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (sample),
		.rec       (push_rec)
	);

	wtws_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_rec   (push_rec),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	wtws_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.done       (done),
		.result     (result)
	);

endmodule

// ===== src/wtws_checker.sv =====
`timescale 1ns / 1ps
`include "window_time_weighted_stats_assert.svh"
module wtws_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input wtws_pkg::out_item_t result
);
	import wtws_pkg::*;

	logic fail_out;
	logic taken;

	assign fail_out = done && (result.status != STATUS_OK);
	assign taken    = start && !busy;

	`WTWS_NEVER(a_status_code, done && (result.status > STATUS_ERROR), "undefined status code")
	`WTWS_ASSERT(a_fail_zero, fail_out |-> (result.stat_value == '0), "nonzero value on failure")
	`WTWS_ASSERT(a_done_spaced, done |=> !done, "results on consecutive cycles")
	`WTWS_ASSERT(a_busy_needs_transfer, !taken |=> !$rose(busy), "busy rose without a transfer")

endmodule

bind window_time_weighted_stats wtws_checker u_wtws_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
